FILE: hdl/spp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pkg: shared types and constants for the sweep-and-prune pair finder
// Body record layout, sizes of the per-body stores and sequencer states.
// ----------------------------------------------------------------------------
package spp_pkg;

    // Sizing
    localparam int MAX_BODIES = 64;
    localparam int COORD_BITS = 32;
    localparam int ID_W       = 6;
    localparam int SLOT_W     = $clog2(MAX_BODIES);
    localparam int CNT_W      = $clog2(MAX_BODIES + 1);

    // One stored body: y extent and static flag
    typedef struct packed {
        logic signed [COORD_BITS-1:0] low_y;
        logic signed [COORD_BITS-1:0] high_y;
        logic                         immovable;
    } body_rec_t;

    localparam int BODY_W = $bits(body_rec_t);

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOK_SLOT,
        ST_LOOK_LIST,
        ST_END_MOVE,
        ST_SCAN,
        ST_FLUSH
    } seq_state_t;

endpackage : spp_pkg
`default_nettype wire

FILE: hdl/spp_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_req_if: endpoint request channel
// Valid/ready channel carrying one sorted box endpoint per request.
// ----------------------------------------------------------------------------
interface spp_req_if;
    import spp_pkg::*;

    logic                         valid;
    logic                         ready;
    logic [ID_W-1:0]              body_id;
    logic                         opens_interval;
    logic signed [COORD_BITS-1:0] lower_y;
    logic signed [COORD_BITS-1:0] upper_y;
    logic                         immovable;

    modport source (
        output valid,
        output body_id,
        output opens_interval,
        output lower_y,
        output upper_y,
        output immovable,
        input  ready
    );

    modport sink (
        input  valid,
        input  body_id,
        input  opens_interval,
        input  lower_y,
        input  upper_y,
        input  immovable,
        output ready
    );

endinterface : spp_req_if
`default_nettype wire

FILE: hdl/spp_pair_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_pair_if: overlapping pair channel
// Valid/ready channel carrying one ordered body pair per request.
// ----------------------------------------------------------------------------
interface spp_pair_if;
    import spp_pkg::*;

    logic            valid;
    logic            ready;
    logic [ID_W-1:0] pair_low;
    logic [ID_W-1:0] pair_high;
    logic            final_pair;

    modport source (
        output valid,
        output pair_low,
        output pair_high,
        output final_pair,
        input  ready
    );

    modport sink (
        input  valid,
        input  pair_low,
        input  pair_high,
        input  final_pair,
        output ready
    );

endinterface : spp_pair_if
`default_nettype wire

FILE: hdl/spp_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
module spp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while re is low
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule : spp_ram
`default_nettype wire

FILE: hdl/sweep_prune_pair_finder.sv
`timescale 1ns / 1ps
`default_nettype none
// Start endpoint: accept, slot and list lookups, a scan of every active body
//   through a three-stage read/compare pipe, then a flush step; an output
//   stall freezes the scan and flush. One request is processed at a time.
// End endpoint: accept and both lookups, plus a move step for an active body.
// Rate is set by the single compare unit and the list RAM read port.
// Reset clears the active count and control state; body stores are not cleared.
// ----------------------------------------------------------------------------
// sweep_prune_pair_finder: 2D sweep-and-prune sweep stage
// Keeps the active set in RAM, tests each new start endpoint for y overlap
// against every active body and emits ordered overlapping pairs.
// ----------------------------------------------------------------------------
module sweep_prune_pair_finder (
    input  wire logic   clk,
    input  wire logic   rst_n,
    spp_req_if.sink     req,
    spp_pair_if.source  pair
);
    import spp_pkg::*;

    // Sequencer and control registers
    seq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic             already_reg, already_next;
    logic             v1_reg, v1_next;
    logic             v2_reg, v2_next;
    logic             held_valid_reg, held_valid_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    logic [ID_W-1:0]              id_reg;
    logic                         start_reg;
    logic signed [COORD_BITS-1:0] lo_reg;
    logic signed [COORD_BITS-1:0] hi_reg;
    logic                         st_reg;
    logic [SLOT_W-1:0]            slot_reg, slot_next;
    logic [ID_W-1:0]              other_reg, other_next;
    logic [ID_W-1:0]              held_low_reg, held_low_next;
    logic [ID_W-1:0]              held_high_reg, held_high_next;
    logic [ID_W-1:0]              out_low_reg, out_low_next;
    logic [ID_W-1:0]              out_high_reg, out_high_next;
    logic                         out_final_reg, out_final_next;

    // RAM ports
    logic              slot_we, slot_re;
    logic [SLOT_W-1:0] slot_waddr, slot_raddr, slot_wdata, slot_rdata;
    logic              list_we, list_re;
    logic [SLOT_W-1:0] list_waddr, list_raddr;
    logic [ID_W-1:0]   list_wdata, list_rdata;
    logic              body_we, body_re;
    logic [SLOT_W-1:0] body_waddr, body_raddr;
    body_rec_t         body_wdata, body_rdata;

    logic             accept;
    logic             id_ok;
    logic             adv;
    logic             issue;
    logic             hit;
    logic             is_active;
    logic [CNT_W-1:0] cnt_minus;
    logic [ID_W-1:0]  new_low, new_high;

    // Per-body stores
    spp_ram #(.WIDTH(SLOT_W), .DEPTH(MAX_BODIES)) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    spp_ram #(.WIDTH(ID_W), .DEPTH(MAX_BODIES)) u_list_ram (
        .clk   (clk),
        .we    (list_we),
        .waddr (list_waddr),
        .wdata (list_wdata),
        .re    (list_re),
        .raddr (list_raddr),
        .rdata (list_rdata)
    );

    spp_ram #(.WIDTH(BODY_W), .DEPTH(MAX_BODIES)) u_body_ram (
        .clk   (clk),
        .we    (body_we),
        .waddr (body_waddr),
        .wdata (body_wdata),
        .re    (body_re),
        .raddr (body_raddr),
        .rdata (body_rdata)
    );

    // Handshake and shared terms
    assign req.ready       = (state_reg == ST_IDLE);
    assign accept          = req.valid && req.ready;
    assign id_ok           = (32'(req.body_id) < MAX_BODIES);
    assign adv             = !out_valid_reg || pair.ready;
    assign cnt_minus       = count_reg - CNT_W'(1);
    assign is_active       = (CNT_W'(slot_reg) < count_reg) && (list_rdata == id_reg);

    assign pair.valid      = out_valid_reg;
    assign pair.pair_low   = out_low_reg;
    assign pair.pair_high  = out_high_reg;
    assign pair.final_pair = out_final_reg;

    // Overlap compare unit: touching extents overlap, static-static skipped
    always_comb
    begin
        hit = (other_reg != id_reg)
            && !(st_reg && body_rdata.immovable)
            && !($signed(hi_reg) < $signed(body_rdata.low_y))
            && !($signed(body_rdata.high_y) < $signed(lo_reg));
        new_low  = (id_reg < other_reg) ? id_reg : other_reg;
        new_high = (id_reg < other_reg) ? other_reg : id_reg;
    end

    // Next state and datapath control
    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        already_next    = already_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        held_valid_next = held_valid_reg;
        held_low_next   = held_low_reg;
        held_high_next  = held_high_reg;
        slot_next       = slot_reg;
        other_next      = other_reg;
        out_valid_next  = out_valid_reg && !pair.ready;
        out_low_next    = out_low_reg;
        out_high_next   = out_high_reg;
        out_final_next  = out_final_reg;
        issue           = 1'b0;

        slot_we    = 1'b0;
        slot_waddr = '0;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = '0;
        list_we    = 1'b0;
        list_waddr = '0;
        list_wdata = '0;
        list_re    = 1'b0;
        list_raddr = '0;
        body_we    = 1'b0;
        body_waddr = '0;
        body_wdata = '0;
        body_re    = 1'b0;
        body_raddr = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Store a start's record now, look up the body's slot
                if (accept && id_ok)
                begin
                    body_we           = req.opens_interval;
                    body_waddr        = SLOT_W'(req.body_id);
                    body_wdata.low_y  = req.lower_y;
                    body_wdata.high_y = req.upper_y;
                    body_wdata.immovable = req.immovable;
                    slot_re           = 1'b1;
                    slot_raddr        = SLOT_W'(req.body_id);
                    state_next        = ST_LOOK_SLOT;
                end
            end

            ST_LOOK_SLOT:
            begin
                slot_next  = slot_rdata;
                list_re    = 1'b1;
                list_raddr = slot_rdata;
                state_next = ST_LOOK_LIST;
            end

            ST_LOOK_LIST:
            begin
                already_next = is_active;
                if (start_reg)
                begin
                    idx_next   = '0;
                    v1_next    = 1'b0;
                    v2_next    = 1'b0;
                    state_next = ST_SCAN;
                end
                else if (is_active)
                begin
                    // Fetch the last entry to move into the freed slot
                    list_re    = 1'b1;
                    list_raddr = cnt_minus[SLOT_W-1:0];
                    state_next = ST_END_MOVE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_END_MOVE:
            begin
                list_we    = 1'b1;
                list_waddr = slot_reg;
                list_wdata = list_rdata;
                slot_we    = 1'b1;
                slot_waddr = SLOT_W'(list_rdata);
                slot_wdata = slot_reg;
                count_next = cnt_minus;
                state_next = ST_IDLE;
            end

            ST_SCAN:
            begin
                // Pipe: list read, body read, compare; frozen while output stalls
                if (adv)
                begin
                    issue = (idx_reg < count_reg);
                    if (issue)
                    begin
                        list_re    = 1'b1;
                        list_raddr = idx_reg[SLOT_W-1:0];
                        idx_next   = idx_reg + CNT_W'(1);
                    end
                    v1_next = issue;
                    if (v1_reg)
                    begin
                        body_re    = 1'b1;
                        body_raddr = SLOT_W'(list_rdata);
                        other_next = list_rdata;
                    end
                    v2_next = v1_reg;
                    // Hold one pair back so the last one can be flagged
                    if (v2_reg && hit)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_low_next   = held_low_reg;
                            out_high_next  = held_high_reg;
                            out_final_next = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_low_next   = new_low;
                        held_high_next  = new_high;
                    end
                end
                if (idx_reg >= count_reg && !v1_reg && !v2_reg)
                begin
                    state_next = ST_FLUSH;
                end
            end

            ST_FLUSH:
            begin
                if (adv)
                begin
                    if (held_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_low_next    = held_low_reg;
                        out_high_next   = held_high_reg;
                        out_final_next  = 1'b1;
                        held_valid_next = 1'b0;
                    end
                    // Append the body to the active set
                    if (!already_reg && count_reg < CNT_W'(MAX_BODIES))
                    begin
                        slot_we    = 1'b1;
                        slot_waddr = SLOT_W'(id_reg);
                        slot_wdata = count_reg[SLOT_W-1:0];
                        list_we    = 1'b1;
                        list_waddr = count_reg[SLOT_W-1:0];
                        list_wdata = id_reg;
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            idx_reg        <= '0;
            already_reg    <= 1'b0;
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            idx_reg        <= idx_next;
            already_reg    <= already_next;
            v1_reg         <= v1_next;
            v2_reg         <= v2_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            id_reg    <= req.body_id;
            start_reg <= req.opens_interval;
            lo_reg    <= req.lower_y;
            hi_reg    <= req.upper_y;
            st_reg    <= req.immovable;
        end
        slot_reg      <= slot_next;
        other_reg     <= other_next;
        held_low_reg  <= held_low_next;
        held_high_reg <= held_high_next;
        out_low_reg   <= out_low_next;
        out_high_reg  <= out_high_next;
        out_final_reg <= out_final_next;
    end

`ifndef SYNTH
    // Active count never exceeds the body capacity
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_BODIES))
        else $error("active count above capacity");

    // A new pair appears only from the scan or flush steps
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg && !pair.ready)) |->
        ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_FLUSH))
        else $error("pair issued outside scan");

    // No held pair survives into idle
    a_held_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !held_valid_reg)
        else $error("held pair left behind");

    // The active count moves by at most one per request step
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |->
        (count_reg == $past(count_reg) + CNT_W'(1) || count_reg == $past(count_reg) - CNT_W'(1)))
        else $error("active count jumped");
`endif

endmodule : sweep_prune_pair_finder
`default_nettype wire
